### hw/rtl/rdlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_pkg
// Shared types and constants of the RPC duplicate-reply LRU cache.
// ----------------------------------------------------------------------------
package rdlc_pkg;

   localparam int RDLC_CACHE_ENTRIES = 64;

   localparam int HOST_W  = 32;
   localparam int PORT_W  = 16;
   localparam int XID_W   = 32;
   localparam int LEN_W   = 16;
   localparam int SLOT_W  = 6;
   localparam int KEY_W   = HOST_W + PORT_W + XID_W;
   localparam int ENTRY_W = KEY_W + LEN_W;

   typedef enum logic [0:0] {
      ACT_LOOKUP = 1'b0,
      ACT_INSERT = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic clr_idx;
      logic scan_en;
      logic age_en;
      logic write_entry;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic pass_done;
      logic hit;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/rdlc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_req_if
// Request channel: lookup or insert of one cache key.
// ----------------------------------------------------------------------------
interface rdlc_req_if
   import rdlc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              action;
   logic [HOST_W-1:0] client_host;
   logic [PORT_W-1:0] client_port;
   logic [XID_W-1:0]  transaction_id;
   logic [LEN_W-1:0]  reply_length;

   modport source (
      output valid, action, client_host, client_port, transaction_id, reply_length,
      input  ready
   );

   modport sink (
      input  valid, action, client_host, client_port, transaction_id, reply_length,
      output ready
   );
endinterface
`default_nettype wire

### hw/rtl/rdlc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_rsp_if
// Response channel: hit, slot, stored length and eviction flag.
// ----------------------------------------------------------------------------
interface rdlc_rsp_if
   import rdlc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0]  stored_length;
   logic              evicted;

   modport source (
      output valid, hit, slot, stored_length, evicted,
      input  ready
   );

   modport sink (
      input  valid, hit, slot, stored_length, evicted,
      output ready
   );
endinterface
`default_nettype wire

### hw/rtl/rdlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdlc_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/rdlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_ctrl
// Sequencer: key search pass, recency aging pass, entry write, response.
// ----------------------------------------------------------------------------
module rdlc_ctrl
   import rdlc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_action,
   output      logic       req_ready,
   input  wire status_type stat,
   output      cmd_type    cmd
);
   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.clr_idx = 1'b1;
               state_in    = (action_type'(req_action) == ACT_INSERT) ? ST_AGE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.pass_done) begin
               cmd.clr_idx = 1'b1;
               state_in    = stat.hit ? ST_AGE : ST_DONE;
            end
         end
         ST_AGE: begin
            cmd.age_en = 1'b1;
            if (stat.pass_done) begin
               state_in = stat.is_insert ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/rdlc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdlc_datapath
// Entry and rank memories, scan counter, match tracking, response register.
// ----------------------------------------------------------------------------
module rdlc_datapath
   import rdlc_pkg::*;
#(
   parameter int CACHE_ENTRIES = RDLC_CACHE_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_action,
   input  wire logic [HOST_W-1:0] req_client_host,
   input  wire logic [PORT_W-1:0] req_client_port,
   input  wire logic [XID_W-1:0]  req_transaction_id,
   input  wire logic [LEN_W-1:0]  req_reply_length,
   input  wire cmd_type           cmd,
   output      status_type        stat,
   rdlc_rsp_if.source             rsp
);
   localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CW = $clog2(CACHE_ENTRIES + 1);

   // captured request
   logic              action_ff;
   logic [HOST_W-1:0] host_ff;
   logic [PORT_W-1:0] port_ff;
   logic [XID_W-1:0]  xid_ff;
   logic [LEN_W-1:0]  len_ff;

   // control state
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_idx_ff;
   logic          found_ff;
   logic          evict_ff;
   logic          rsp_valid_ff;

   // working payload
   logic [AW-1:0]    target_ff;
   logic [AW-1:0]    limit_ff;
   logic [LEN_W-1:0] best_len_ff;

   // response payload
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_evict_ff;

   logic               full;
   logic               issue;
   logic [ENTRY_W-1:0] entry_rd;
   logic [AW-1:0]      rank_rd;
   logic               key_match;
   logic               rank_wr_en;
   logic [AW-1:0]      rank_wr_addr;
   logic [AW-1:0]      rank_wr_data;
   logic [AW-1:0]      rank_aged;

   assign full  = (count_ff == CW'(CACHE_ENTRIES));
   assign issue = (cmd.scan_en || cmd.age_en) && (idx_ff < count_ff);

   assign key_match = (entry_rd[ENTRY_W-1:LEN_W] == {host_ff, port_ff, xid_ff});

   always_comb begin
      if (rank_rd == limit_ff) begin
         rank_aged = '0;
      end else if (rank_rd < limit_ff) begin
         rank_aged = rank_rd + AW'(1);
      end else begin
         rank_aged = rank_rd;
      end
   end

   always_comb begin
      rank_wr_en   = 1'b0;
      rank_wr_addr = pend_idx_ff;
      rank_wr_data = rank_aged;
      if (cmd.write_entry) begin
         rank_wr_en   = 1'b1;
         rank_wr_addr = target_ff;
         rank_wr_data = '0;
      end else if (cmd.age_en && pend_ff) begin
         rank_wr_en = 1'b1;
      end
   end

   rdlc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (target_ff),
      .wr_data ({host_ff, port_ff, xid_ff, len_ff}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (entry_rd)
   );

   rdlc_ram #(
      .WIDTH (AW),
      .DEPTH (CACHE_ENTRIES)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rank_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (cmd.clr_idx) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.capture) begin
            found_ff <= 1'b0;
            evict_ff <= full && (action_type'(req_action) == ACT_INSERT);
         end else if (cmd.scan_en && pend_ff && key_match &&
                      (!found_ff || rank_rd < limit_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.write_entry && !full) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= idx_ff[AW-1:0];
      if (cmd.capture) begin
         action_ff   <= req_action;
         host_ff     <= req_client_host;
         port_ff     <= req_client_port;
         xid_ff      <= req_transaction_id;
         len_ff      <= req_reply_length;
         best_len_ff <= '0;
         // free slot is the fill count; a full insert takes the oldest rank
         limit_ff    <= full ? AW'(CACHE_ENTRIES - 1) : count_ff[AW-1:0];
         target_ff   <= (action_type'(req_action) == ACT_INSERT && !full) ?
                        count_ff[AW-1:0] : '0;
      end else if (cmd.scan_en && pend_ff) begin
         if (key_match && (!found_ff || rank_rd < limit_ff)) begin
            target_ff   <= pend_idx_ff;
            limit_ff    <= rank_rd;
            best_len_ff <= entry_rd[LEN_W-1:0];
         end
      end else if (cmd.age_en && pend_ff) begin
         if (rank_rd == limit_ff) begin
            target_ff <= pend_idx_ff;
         end
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff   <= found_ff;
         rsp_slot_ff  <= SLOT_W'(target_ff);
         rsp_len_ff   <= best_len_ff;
         rsp_evict_ff <= evict_ff;
      end
   end

   assign stat.is_insert = (action_type'(action_ff) == ACT_INSERT);
   assign stat.pass_done = (idx_ff >= count_ff) && !pend_ff;
   assign stat.hit       = found_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.slot          = rsp_slot_ff;
   assign rsp.stored_length = rsp_len_ff;
   assign rsp.evicted       = rsp_evict_ff;
endmodule
`default_nettype wire

### hw/rtl/rpc_duplicate_reply_lru_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_duplicate_reply_lru_cache
// Duplicate-reply cache for an RPC server, kept in least-recently-used order.
// ----------------------------------------------------------------------------
// One request at a time. A lookup miss runs a search pass over the valid
// entries, a lookup hit a search pass and then a recency update pass, and an
// insert a recency update pass and then the entry write; the passes are paced
// by the single read port of the entry and rank memories, which are walked one
// entry per cycle. The result sits in an output register, so the next request
// is taken while it waits. Slots fill from zero upward and stay filled, so a
// fill count marks the valid entries and no clearing pass is needed after
// reset. The slot field carries the low six bits of the slot number.
// ----------------------------------------------------------------------------
module rpc_duplicate_reply_lru_cache
   import rdlc_pkg::*;
#(
   parameter int CACHE_ENTRIES = RDLC_CACHE_ENTRIES
) (
   input wire logic   clock,
   input wire logic   reset,
   rdlc_req_if.sink   req,
   rdlc_rsp_if.source rsp
);
   cmd_type    cmd;
   status_type stat;
   logic       req_ready;

   assign req.ready = req_ready;

   rdlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rdlc_datapath #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req.action),
      .req_client_host    (req.client_host),
      .req_client_port    (req.client_port),
      .req_transaction_id (req.transaction_id),
      .req_reply_length   (req.reply_length),
      .cmd                (cmd),
      .stat               (stat),
      .rsp                (rsp)
   );

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready
   ) else $error("request taken while a transaction is in progress");

   a_no_result_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp.valid || rsp.ready)
   ) else $error("pending result overwritten");

   a_write_only_on_insert: assert property (
      @(posedge clock) disable iff (reset)
      cmd.write_entry |-> stat.is_insert
   ) else $error("entry write outside an insert");

   a_hit_not_evicted: assert property (
      @(posedge clock) disable iff (reset)
      cmd.load_rsp |=> !(rsp.hit && rsp.evicted)
   ) else $error("result reports both hit and eviction");
endmodule
`default_nettype wire
